[rtl/numeric_range_parse_apply_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the numeric range parser
// Clocked immediate-implication and next-cycle-implication checks that are
// disabled while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef NUMERIC_RANGE_PARSE_APPLY_MACROS_SVH
`define NUMERIC_RANGE_PARSE_APPLY_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NRPA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NRPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/nrpa_pkg.sv]
// ---------------------------------------------------------------------------
// nrpa_pkg
// Types and codes shared by the numeric range parser.
// ---------------------------------------------------------------------------
package nrpa_pkg;

    localparam int OUT_BITS = 31;

    typedef logic [1:0] phase_t;
    typedef logic [2:0] status_t;

    // Parser phases
    localparam phase_t PH_START0 = 2'd0;   // expect first start digit
    localparam phase_t PH_START  = 2'd1;   // in start digits
    localparam phase_t PH_END0   = 2'd2;   // expect first end digit
    localparam phase_t PH_END    = 2'd3;   // in end digits

    // Result status codes
    localparam status_t ST_PASS    = 3'd0;
    localparam status_t ST_SINGLE  = 3'd1;
    localparam status_t ST_RANGE   = 3'd2;
    localparam status_t ST_INVALID = 3'd3;
    localparam status_t ST_NODATA  = 3'd4;

    // Characters of the range grammar
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

endpackage

[rtl/numeric_range_parse_apply.sv]
// ---------------------------------------------------------------------------
// numeric_range_parse_apply
// Parses a one-dimension index range text ("N" or "N:M") one character per
// transfer and resolves it against the target array's shape.
// ---------------------------------------------------------------------------
// Usage:
//   Slave side carries one character per transfer in s_tdata[7:0] together
//   with the target array length in s_tdata[39:8] and the array flag in
//   s_tuser; s_tlast marks the final character of a range text. Shape fields
//   are only looked at on the transfer with s_tlast set.
//   Master side gives one result per range text: status in m_tuser, first
//   index in m_tdata[30:0] and last index in m_tdata[61:31].
//   Throughput: one character per cycle while the master side keeps up. The character decode
//   and the saturating multiply-by-ten accumulator update form one register
//   stage; the final compares and clamp form the next.
//   The last character's range is captured in the finish register and its
//   result then in the output register, which drives m_tvalid.
//   Reset clears the parser to "expect first start digit" and empties both
//   result stages. When the master side stalls, the output and finish
//   registers hold; s_tready drops only once both are full.
// ---------------------------------------------------------------------------
`include "numeric_range_parse_apply_macros.svh"

module numeric_range_parse_apply
    import nrpa_pkg::*;
#(
    parameter int INDEX_BITS = 31
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // ch[7:0], array_len[39:8]
    input  logic        s_tlast,
    input  logic        s_tuser,    // array_flag[0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // first_index[30:0], last_index[61:31], zero pad
    output logic [2:0]  m_tuser     // status[2:0]
);

    localparam int PUSH_BITS = INDEX_BITS + 4;

    typedef logic [INDEX_BITS-1:0] acc_t;

    // Saturating acc * 10 + digit
    function automatic acc_t acc_push(input acc_t acc, input logic [3:0] dig);
        logic [PUSH_BITS-1:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + PUSH_BITS'(dig);
        return (|v[PUSH_BITS-1:INDEX_BITS]) ? '1 : v[INDEX_BITS-1:0];
    endfunction

    logic [7:0]        ch;
    logic              is_digit;
    logic [3:0]        dig;
    logic              s_accept;
    logic              fin_ready;
    logic              out_ready;

    // Parser state
    phase_t            phase_reg, phase_next;
    logic              err_reg, err_next;
    acc_t              start_reg, start_next;
    acc_t              end_reg, end_next;

    // State after the current character
    phase_t            upd_phase;
    logic              upd_err;
    acc_t              upd_start;
    acc_t              upd_end;

    // Finish stage
    logic              fin_valid_reg, fin_valid_next;
    phase_t            fin_phase_reg;
    logic              fin_err_reg;
    acc_t              fin_start_reg;
    acc_t              fin_end_reg;
    logic              fin_arr_reg;
    logic [31:0]       fin_len_reg;

    // Result computation
    status_t           res_status;
    logic [OUT_BITS-1:0] res_first;
    logic [OUT_BITS-1:0] res_last;
    logic              len_pos;
    logic [31:0]       start_ext;
    logic [31:0]       end_ext;
    logic [31:0]       len_m1;

    // Output register
    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [OUT_BITS-1:0] out_first_reg;
    logic [OUT_BITS-1:0] out_last_reg;

    assign ch        = s_tdata[7:0];
    assign is_digit  = ch inside {[CH_ZERO:CH_NINE]};
    assign dig       = 4'(ch - CH_ZERO);

    assign out_ready = !out_valid_reg || m_tready;
    assign fin_ready = !fin_valid_reg || out_ready;
    assign s_tready  = fin_ready;
    assign s_accept  = s_tvalid && s_tready;

    // -----------------------------------------------------------------------
    // Character decode
    // -----------------------------------------------------------------------
    always_comb
    begin
        upd_phase = phase_reg;
        upd_err   = err_reg;
        upd_start = start_reg;
        upd_end   = end_reg;
        // Once an error is flagged, ignore characters until the last one
        if (!err_reg)
        begin
            case (phase_reg)
                PH_START0:
                begin
                    if (is_digit)
                    begin
                        upd_start = INDEX_BITS'(dig);
                        upd_phase = PH_START;
                    end
                    else
                    begin
                        upd_err = 1'b1;
                    end
                end
                PH_START:
                begin
                    if (is_digit)
                        upd_start = acc_push(start_reg, dig);
                    else if (ch == CH_COLON)
                        upd_phase = PH_END0;
                    else
                        upd_err = 1'b1;
                end
                PH_END0:
                begin
                    if (is_digit)
                    begin
                        upd_end   = INDEX_BITS'(dig);
                        upd_phase = PH_END;
                    end
                    else
                    begin
                        upd_err = 1'b1;
                    end
                end
                PH_END:
                begin
                    if (is_digit)
                        upd_end = acc_push(end_reg, dig);
                    else
                        upd_err = 1'b1;
                end
                default:
                begin
                    upd_err = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        err_next   = err_reg;
        start_next = start_reg;
        end_next   = end_reg;
        if (s_accept)
        begin
            if (s_tlast)
            begin
                // Return to the idle parse state for the next range text
                phase_next = PH_START0;
                err_next   = 1'b0;
                start_next = '0;
                end_next   = '0;
            end
            else
            begin
                phase_next = upd_phase;
                err_next   = upd_err;
                start_next = upd_start;
                end_next   = upd_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START0;
            err_reg   <= 1'b0;
            start_reg <= '0;
            end_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            err_reg   <= err_next;
            start_reg <= start_next;
            end_reg   <= end_next;
        end
    end

    // -----------------------------------------------------------------------
    // Finish stage: capture the parsed range and shape on the last character
    // -----------------------------------------------------------------------
    assign fin_valid_next = fin_ready ? (s_accept && s_tlast) : fin_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_valid_reg <= 1'b0;
        else
            fin_valid_reg <= fin_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && s_tlast)
        begin
            fin_phase_reg <= upd_phase;
            fin_err_reg   <= upd_err;
            fin_start_reg <= upd_start;
            fin_end_reg   <= upd_end;
            fin_arr_reg   <= s_tuser;
            fin_len_reg   <= s_tdata[39:8];
        end
    end

    // -----------------------------------------------------------------------
    // Resolve against the array shape
    // -----------------------------------------------------------------------
    assign len_pos   = (fin_len_reg != 32'd0) && !fin_len_reg[31];
    assign start_ext = 32'(fin_start_reg);
    assign end_ext   = 32'(fin_end_reg);
    assign len_m1    = fin_len_reg - 32'd1;

    always_comb
    begin
        res_status = ST_PASS;
        res_first  = '0;
        res_last   = '0;
        if (!fin_arr_reg || !len_pos)
        begin
            res_status = ST_PASS;
        end
        else if (fin_err_reg || fin_phase_reg == PH_START0 || fin_phase_reg == PH_END0)
        begin
            res_status = ST_INVALID;
        end
        else if (fin_phase_reg == PH_END && start_ext >= end_ext)
        begin
            res_status = ST_INVALID;
        end
        else if (start_ext >= fin_len_reg)
        begin
            res_status = ST_NODATA;
        end
        else if (fin_phase_reg == PH_START)
        begin
            res_status = ST_SINGLE;
            res_first  = OUT_BITS'(fin_start_reg);
            res_last   = OUT_BITS'(fin_start_reg);
        end
        else
        begin
            // Clamp the end to the last element of the array
            res_status = ST_RANGE;
            res_first  = OUT_BITS'(fin_start_reg);
            res_last   = (end_ext >= fin_len_reg) ? len_m1[OUT_BITS-1:0]
                                                  : OUT_BITS'(fin_end_reg);
        end
    end

    // -----------------------------------------------------------------------
    // Output register
    // -----------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= fin_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && fin_valid_reg)
        begin
            out_status_reg <= res_status;
            out_first_reg  <= res_first;
            out_last_reg   <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {2'b00, out_last_reg, out_first_reg};

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `NRPA_ASSERT_NEXT(a_last_clears_parser, clk, rst_n, s_accept && s_tlast,
        phase_reg == PH_START0 && !err_reg && fin_valid_reg,
        "parser not cleared or finish stage empty after last character")

    `NRPA_ASSERT_NEXT(a_fin_holds_on_stall, clk, rst_n, fin_valid_reg && !out_ready,
        fin_valid_reg && $stable(fin_start_reg) && $stable(fin_len_reg),
        "finish stage lost its range while the output was stalled")

    `NRPA_ASSERT_NOW(a_single_indices, clk, rst_n, m_tvalid && m_tuser == ST_SINGLE,
        m_tdata[30:0] == m_tdata[61:31],
        "single element result with differing first and last index")

    `NRPA_ASSERT_NOW(a_range_order, clk, rst_n, m_tvalid && m_tuser == ST_RANGE,
        m_tdata[30:0] <= m_tdata[61:31],
        "subrange result with first index past last index")

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb - testbench for numeric_range_parse_apply
// Streams index range texts one character per transfer, predicts the
// selection that each text resolves to, and compares every result
// transfer against the oldest prediction. Both stream sides idle at random.
// ---------------------------------------------------------------------------
module tb;
    import nrpa_pkg::*;

    typedef struct {
        status_t     status;
        logic [30:0] first_ix;
        logic [30:0] last_ix;
    } sel_t;

    localparam longint unsigned IDX_MAX = 64'h7FFF_FFFF;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // ch[7:0], array_len[39:8]
    logic        s_tlast;
    logic        s_tuser;   // array_flag[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // first_index[30:0], last_index[61:31], zero pad
    logic [2:0]  m_tuser;   // status[2:0]

    // predictor state
    phase_t          rng_phase;
    bit              parse_err;
    longint unsigned start_val;
    longint unsigned end_val;

    sel_t        want_sel_q[$];
    logic [7:0]  text_q[$];
    int          err_cnt;
    int          chars_sent;
    bit          no_idle;

    numeric_range_parse_apply uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned sat_push(longint unsigned acc, longint unsigned d);
        longint unsigned v;
        v = acc * 10 + d;
        return (v > IDX_MAX) ? IDX_MAX : v;
    endfunction

    // Advance the parser copy by one character; on the final one, queue the
    // selection it resolves to and return to the idle parse state.
    task automatic take_range_char(logic [7:0] c, bit fin, bit arr, logic [31:0] len);
        bit              dig;
        longint unsigned d;
        longint unsigned ulen;
        sel_t            r;
        dig  = (c >= CH_ZERO) && (c <= CH_NINE);
        d    = dig ? longint'(c - CH_ZERO) : 0;
        ulen = longint'(len) & 64'hFFFF_FFFF;
        if (!parse_err)
        begin
            case (rng_phase)
                PH_START0:
                    if (dig)
                    begin
                        start_val = d;
                        rng_phase = PH_START;
                    end
                    else
                        parse_err = 1'b1;
                PH_START:
                    if (dig)
                        start_val = sat_push(start_val, d);
                    else if (c == CH_COLON)
                        rng_phase = PH_END0;
                    else
                        parse_err = 1'b1;
                PH_END0:
                    if (dig)
                    begin
                        end_val   = d;
                        rng_phase = PH_END;
                    end
                    else
                        parse_err = 1'b1;
                default:
                    if (dig)
                        end_val = sat_push(end_val, d);
                    else
                        parse_err = 1'b1;
            endcase
        end
        if (fin)
        begin
            r.status   = ST_PASS;
            r.first_ix = '0;
            r.last_ix  = '0;
            if (!arr || len == 32'd0 || len[31])
                r.status = ST_PASS;
            else if (parse_err || rng_phase == PH_START0 || rng_phase == PH_END0)
                r.status = ST_INVALID;
            else if (rng_phase == PH_END && start_val >= end_val)
                r.status = ST_INVALID;
            else if (start_val >= ulen)
                r.status = ST_NODATA;
            else if (rng_phase == PH_START)
            begin
                r.status   = ST_SINGLE;
                r.first_ix = start_val[30:0];
                r.last_ix  = start_val[30:0];
            end
            else
            begin
                r.status   = ST_RANGE;
                r.first_ix = start_val[30:0];
                r.last_ix  = (end_val >= ulen) ? 31'(ulen - 1) : end_val[30:0];
            end
            want_sel_q.push_back(r);
            rng_phase = PH_START0;
            parse_err = 1'b0;
            start_val = 0;
            end_val   = 0;
        end
    endtask

    // Send one character; valid stays high into the next call when no gap is drawn.
    task automatic send_char(logic [7:0] c, bit fin, bit arr, logic [31:0] len);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {len, c};
        s_tlast  <= fin;
        s_tuser  <= arr;
        do
            @(posedge clk);
        while (!s_tready);
        take_range_char(c, fin, arr, len);
        chars_sent++;
    endtask

    // Send the buffered text; shape fields on non-final characters are junk.
    task automatic send_text(bit arr, logic [31:0] len);
        for (int i = 0; i < text_q.size(); i++)
        begin
            if (i == text_q.size() - 1)
                send_char(text_q[i], 1'b1, arr, len);
            else
                send_char(text_q[i], 1'b0, 1'($urandom_range(0, 1)), $urandom);
        end
        text_q.delete();
    endtask

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    function automatic void put_digits(longint unsigned v);
        put_str($sformatf("%0d", v));
    endfunction

    // Result side: hold ready low for a drawn stall, then wait for one transfer.
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        sel_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (want_sel_q.size() == 0)
            begin
                $error("unexpected result: status %0d first %0d last %0d",
                       m_tuser, m_tdata[30:0], m_tdata[61:31]);
                err_cnt++;
            end
            else
            begin
                w = want_sel_q.pop_front();
                if (m_tuser !== w.status)
                begin
                    $error("status: expected %0d, got %0d", w.status, m_tuser);
                    err_cnt++;
                end
                if (m_tdata[30:0] !== w.first_ix)
                begin
                    $error("first_index: expected %0d, got %0d", w.first_ix, m_tdata[30:0]);
                    err_cnt++;
                end
                if (m_tdata[61:31] !== w.last_ix)
                begin
                    $error("last_index: expected %0d, got %0d", w.last_ix, m_tdata[61:31]);
                    err_cnt++;
                end
            end
        end
    end

    task automatic test_selections();
        put_str("0");      send_text(1'b1, 32'd1);      // single, smallest array
        put_str("2:7");    send_text(1'b1, 32'd5);      // end clamped to array
        put_str("1:3");    send_text(1'b1, 32'd10);
        put_str("5");      send_text(1'b1, 32'd3);      // start past array
        put_str("3:3");    send_text(1'b1, 32'd10);     // start not below end
        put_str("9:2");    send_text(1'b1, 32'd10);
    endtask

    task automatic test_syntax_errors();
        put_str(":");      send_text(1'b1, 32'd4);      // missing start digit
        put_str("1:");     send_text(1'b1, 32'd4);      // missing end digit
        put_str("1::2");   send_text(1'b1, 32'd4);      // second colon
        text_q.push_back(8'h00); send_text(1'b1, 32'd4);
        text_q.push_back(8'hFF); send_text(1'b1, 32'd4);
        put_str("/;");     send_text(1'b1, 32'd4);      // neighbors of digits and colon
        put_str("1a2");    send_text(1'b1, 32'd4);      // error stays set
    endtask

    task automatic test_pass_through();
        put_str("1");      send_text(1'b0, 32'd4);      // not an array
        put_str("x");      send_text(1'b1, 32'd0);      // bad syntax, length zero
        put_str("0");      send_text(1'b1, 32'h8000_0000);
        put_str("0");      send_text(1'b1, 32'hFFFF_FFFF);
    endtask

    task automatic test_saturation();
        put_str("99999999999");   send_text(1'b1, 32'h7FFF_FFFF);  // saturates, no data
        put_str("2147483646");    send_text(1'b1, 32'h7FFF_FFFF);
        put_str("0:99999999999"); send_text(1'b1, 32'h7FFF_FFFF);
    endtask

    function automatic longint unsigned pick_index();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(0, 40);
        else if (r < 8)
            return $urandom_range(0, 100000);
        else if (r == 8)
            return $urandom;
        return longint'($urandom) * $urandom_range(1, 30);
    endfunction

    function automatic logic [31:0] pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(1, 48);
        else if (r == 6)
            return $urandom;
        else if (r == 7)
        begin
            case ($urandom_range(0, 2))
                0:       return 32'd0;
                1:       return 32'hFFFF_FFFF;
                default: return 32'h8000_0000;
            endcase
        end
        else if (r == 8)
            return 32'h7FFF_FFFF;
        return $urandom_range(1, 200000);
    endfunction

    task automatic test_random();
        int              kind;
        int              pos;
        int              base;
        longint unsigned a;
        longint unsigned b;
        base = chars_sent;
        while (chars_sent - base < 1200)
        begin
            no_idle = ($urandom_range(0, 7) == 0);
            kind    = $urandom_range(0, 99);
            if (kind < 5)
            begin
                repeat ($urandom_range(1, 4))
                    text_q.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                a = pick_index();
                if ($urandom_range(0, 9) == 0)
                    text_q.push_back(CH_ZERO);     // leading zero
                put_digits(a);
                if ($urandom_range(0, 1) == 1)
                begin
                    text_q.push_back(CH_COLON);
                    case ($urandom_range(0, 4))
                        0, 1, 2: b = a + $urandom_range(1, 30);
                        3:       b = $urandom_range(0, 30);
                        default: b = pick_index();
                    endcase
                    put_digits(b);
                end
                // break a share of the well-formed texts
                if (kind >= 80)
                begin
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            pos = $urandom_range(0, text_q.size());
                            text_q.insert(pos, 8'($urandom_range(0, 255)));
                        end
                        1:       text_q.push_back(CH_COLON);
                        2:       text_q.push_front(CH_COLON);
                        default: if (text_q.size() > 1) void'(text_q.pop_back());
                    endcase
                end
            end
            send_text(($urandom_range(0, 9) != 0), pick_len());
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tlast    <= 1'b0;
        s_tuser    <= 1'b0;
        err_cnt    = 0;
        chars_sent = 0;
        no_idle    = 1'b0;
        rng_phase  = PH_START0;
        parse_err  = 1'b0;
        start_val  = 0;
        end_val    = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_selections();
        test_syntax_errors();
        test_pass_through();
        test_saturation();
        test_random();

        s_tvalid <= 1'b0;
        while (want_sel_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (err_cnt == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/nrpa_pkg.sv
rtl/numeric_range_parse_apply.sv
tb/sv/tb.sv
